@@ hw/rtl/itda_pkg.sv @@
package itda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int NUM_DIGITS = 10;   // 2147483648 has ten digits

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ERR   = 7'h00;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [6:0]                min_width;
    } req_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last;
        logic       error;
    } rsp_t;

endpackage

@@ hw/rtl/itda_bcd_cell.sv @@
// One BCD digit of the double-dabble chain.
module itda_bcd_cell
    import itda_pkg::*;
(
    input  logic       clk,
    input  logic       clr,
    input  logic       shift_en,
    input  logic       shift_in,
    output logic       shift_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 before the shift when the digit would overflow past 9
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign shift_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (clr)
        begin
            digit_next = 4'd0;
        end
        else if (shift_en)
        begin
            digit_next = {adj[2:0], shift_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

@@ hw/rtl/int_to_decimal_ascii_padded.sv @@
// Sequence: accept, a 32-step shift through the BCD cell chain, a width
//   check, then one character per cycle while the output is not stalled
//   (sign, pad zeros, digits) into the output register. Over-limit widths
//   go from accept straight to the error character. A new request is taken
//   only once the previous one has issued its last or error character.
// Reset: rst_n asynchronous, active low; clears the sequencer and output valid.
module int_to_decimal_ascii_padded
    import itda_pkg::*;
#(
    parameter int MAX_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    localparam int PW = $clog2(MAX_WIDTH);
    localparam logic [7:0] MAXW8 = 8'(MAX_WIDTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [6:0]         width_reg, width_next;
    logic               sign_reg, sign_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic accept;
    logic slot_free;
    logic cell_clr;
    logic cell_shift;
    logic [NUM_DIGITS:0] carry;
    logic [3:0] digit [NUM_DIGITS];

    logic [3:0] num_digits;
    logic [6:0] natural_len;
    logic [6:0] total_len;
    logic [3:0] sel_digit;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // ------------------------------------------------------------------
    // Double-dabble chain: magnitude enters MSB first at cell 0, each cell
    // passes its top bit up to the next, one shift per cycle.
    // ------------------------------------------------------------------
    assign cell_clr   = accept;
    assign cell_shift = (state_reg == ST_CONV);
    assign carry[0]   = mag_reg[VALUE_W-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++)
        begin : g_cell
            itda_bcd_cell u_cell (
                .clk       (clk),
                .clr       (cell_clr),
                .shift_en  (cell_shift),
                .shift_in  (carry[g]),
                .shift_out (carry[g+1]),
                .digit     (digit[g])
            );
        end
    endgenerate

    // significant digit count (at least one, for zero)
    always_comb
    begin
        num_digits = 4'd1;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (digit[i] != 4'd0)
            begin
                num_digits = 4'(i + 1);
            end
        end
    end

    assign natural_len = {3'd0, num_digits} + {6'd0, neg_reg};
    assign total_len   = (width_reg > natural_len) ? width_reg : natural_len;

    // positions above the top BCD digit are pad zeros
    assign sel_digit = ({{(8-PW){1'b0}}, pos_reg} < 8'(NUM_DIGITS)) ?
                       digit[pos_reg[3:0]] : 4'd0;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        width_next     = width_reg;
        sign_next      = sign_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = req_data.value[VALUE_W-1];
                    mag_next   = req_data.value[VALUE_W-1] ?
                                 (~req_data.value + 1'b1) : req_data.value;
                    width_next = req_data.min_width;
                    cnt_next   = '0;
                    if ({1'b0, req_data.min_width} > MAXW8)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (width_reg != 7'd0 && width_reg < natural_len)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    sign_next  = neg_reg;
                    // the sign takes one of the total positions
                    pos_next   = PW'(total_len - 7'd1 - {6'd0, neg_reg});
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.error = 1'b0;
                    if (sign_reg)
                    begin
                        rsp_next.out_char = CHAR_MINUS;
                        rsp_next.last     = 1'b0;   // sign is never alone
                        sign_next         = 1'b0;
                    end
                    else
                    begin
                        rsp_next.out_char = CHAR_ZERO + {3'd0, sel_digit};
                        rsp_next.last     = (pos_reg == '0);
                        if (pos_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.out_char = CHAR_ERR;
                    rsp_next.last     = 1'b1;
                    rsp_next.error    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        width_reg <= width_next;
        sign_reg  <= sign_next;
        pos_reg   <= pos_next;
        rsp_reg   <= rsp_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.error |-> rsp_data.last)
        else $error("error response without last");

    a_over_limit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ({1'b0, req_data.min_width} > MAXW8) |=> state_reg == ST_ERR)
        else $error("over-limit width not flagged");

    a_conv_runs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONV && cnt_reg != CNT_W'(VALUE_W - 1)
        |=> state_reg == ST_CONV)
        else $error("conversion cut short");

    a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT || state_reg == ST_CONV |-> !accept)
        else $error("request accepted while busy");

endmodule

@@ tb/sv/int_to_decimal_ascii_padded_test.sv @@
`timescale 1ns / 100ps

// Stimulus, prediction and checking for the signed integer to padded decimal text block.
// Each accepted request is expanded into the characters it should produce.
// Every character that leaves the block is compared with the oldest expected one.
module int_to_decimal_ascii_padded_test;
    import itda_pkg::*;

    localparam int WIDTH_LIMIT = 32;     // MAX_WIDTH given to the block
    localparam int RANDOM_REQS = 136;
    localparam int DRAIN_EVERY = 40;     // sender waits for an empty queue this often
    localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 120;    // quiet time after the last character
    localparam int MAX_REPORTS = 10;

    // One row of the directed table. When fixed is set, resp is the whole answer:
    // a single character, typed in by hand. Other rows go through the predictor.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [6:0]                width;
        logic                      fixed;
        rsp_t                      resp;
    } dir_row_t;

    localparam int NUM_DIR = 24;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    rsp_t     expected_chars [$];   // characters still owed by the block
    int       mismatches;
    int       quiet_cycles;
    bit       req_calm;             // sender runs with no gaps while set
    dir_row_t dir_rows [NUM_DIR];

    int_to_decimal_ascii_padded #(
        .MAX_WIDTH (WIDTH_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Characters needed for the bare number: digits, plus one for a minus sign.
    function automatic int natural_len(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        int                 nd;
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        nd  = 0;
        do
        begin
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        return nd + (raw[VALUE_W-1] ? 1 : 0);
    endfunction

    // Expand one request into the characters the block owes for it.
    function automatic void predict_text(input req_t r);
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit [NUM_DIGITS];
        int                 nd;
        int                 natural;
        int                 total;
        rsp_t               c;
        raw = r.value;
        // Width over the limit is rejected before anything else is looked at.
        if (r.min_width > WIDTH_LIMIT)
        begin
            expected_chars.push_back('{out_char: CHAR_ERR, last: 1'b1, error: 1'b1});
            return;
        end
        // Negating 32'h8000_0000 unsigned gives 2147483648, which is the magnitude wanted.
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        nd  = 0;
        do
        begin
            digit[nd] = 4'(mag % 10);
            nd++;
            mag = mag / 10;
        end while (mag != 0);
        natural = natural_len(raw);
        // A nonzero width narrower than the bare number is rejected too.
        if (r.min_width != 0 && int'(r.min_width) < natural)
        begin
            expected_chars.push_back('{out_char: CHAR_ERR, last: 1'b1, error: 1'b1});
            return;
        end
        total = (int'(r.min_width) > natural) ? int'(r.min_width) : natural;
        // Order on the wire: sign, then pad zeros, then digits, most significant first.
        for (int k = 0; k < total; k++)
        begin
            if (raw[VALUE_W-1] && k == 0)
                c.out_char = CHAR_MINUS;
            else if (k < total - nd)
                c.out_char = CHAR_ZERO;
            else
                c.out_char = CHAR_ZERO + 7'(digit[total - 1 - k]);
            c.last  = (k == total - 1);
            c.error = 1'b0;
            expected_chars.push_back(c);
        end
    endfunction

    task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected char=%02h last=%0b error=%0b, %s",
                     $realtime, what, want.out_char, want.last, want.error,
                     $sformatf("got char=%02h last=%0b error=%0b",
                               got.out_char, got.last, got.error));
    endtask

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Present one request from the falling edge on and hold it until it is taken.
    // valid stays high across back-to-back requests; a gap lowers it first.
    task automatic send_req(input req_t r, input logic fixed, input rsp_t fixed_resp);
        int gap;
        gap = req_calm ? 0 : idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        if (fixed)
            expected_chars.push_back(fixed_resp);
        else
            predict_text(r);
    endtask

    // Lower valid, then hold off until every owed character has come out.
    task automatic drain_chars();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: runs of ready cycles broken by stalls; sometimes a stretch without stalls.
    initial
    begin : rsp_stall_gen
        int  run;
        int  hold;
        bit  calm;
        rsp_stall = 1'b0;
        calm      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                calm = ~calm;
            run = $urandom_range(1, 20);
            repeat (run) @(negedge clk) rsp_stall <= 1'b0;
            hold = calm ? 0 : idle_len();
            repeat (hold) @(negedge clk) rsp_stall <= 1'b1;
        end
    end

    // Scoreboard: each character taken is held against the oldest expected one.
    always @(posedge clk)
    begin : check_chars
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_chars.size() == 0)
                note_mismatch("unexpected character", '0, rsp_data);
            else
            begin
                want = expected_chars.pop_front();
                if (rsp_data.out_char !== want.out_char || rsp_data.last !== want.last ||
                    rsp_data.error !== want.error)
                    note_mismatch("character mismatch", want, rsp_data);
            end
        end
    end

    // Watchdog: only cycles with no handshake on either side count.
    // A conversion alone makes a quiet stretch; long gaps and stalls add to it.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : main_seq
        req_t r;
        int   pick;
        int   k;
        int   natural;
        int   p10;
        logic [VALUE_W-1:0] mag;

        req_valid    = 1'b0;
        req_data     = '0;
        rst_n        = 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        req_calm     = 1'b0;

        // Hand-typed rows: errors and one-character answers.
        // Everything longer is left to the predictor.
        dir_rows = '{
            // zero with no padding, and a one-digit exact fit
            '{32'sd0,           7'd0,   1'b1, '{CHAR_ZERO,        1'b1, 1'b0}},
            '{32'sd7,           7'd1,   1'b1, '{CHAR_ZERO + 7'd7, 1'b1, 1'b0}},
            // width over the limit: just above, at the top of the field, bit 6 alone
            '{32'sd0,           7'd33,  1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            '{-32'sd1,          7'd127, 1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            '{-32'sd9,          7'd64,  1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            // width too small; the sign counts toward the length
            '{32'sd12345,       7'd3,   1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            '{-32'sd5,          7'd1,   1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            '{-32'sd2147483648, 7'd10,  1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            '{32'sd2147483647,  7'd9,   1'b1, '{CHAR_ERR,         1'b1, 1'b1}},
            // most negative value: bare, exact fit, widest
            '{-32'sd2147483648, 7'd0,   1'b0, '0},
            '{-32'sd2147483648, 7'd11,  1'b0, '0},
            '{-32'sd2147483648, 7'd32,  1'b0, '0},
            // most positive value
            '{32'sd2147483647,  7'd0,   1'b0, '0},
            '{32'sd2147483647,  7'd10,  1'b0, '0},
            '{32'sd2147483647,  7'd32,  1'b0, '0},
            // zero and minus one at several widths
            '{32'sd0,           7'd32,  1'b0, '0},
            '{-32'sd1,          7'd0,   1'b0, '0},
            '{-32'sd1,          7'd2,   1'b0, '0},
            '{-32'sd1,          7'd5,   1'b0, '0},
            // ordinary values: bare, exact fit, padded
            '{32'sd42,          7'd0,   1'b0, '0},
            '{32'sd42,          7'd2,   1'b0, '0},
            '{32'sd1000000000,  7'd12,  1'b0, '0},
            '{-32'sd123,        7'd4,   1'b0, '0},
            '{32'sd1,           7'd31,  1'b0, '0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++)
        begin
            r.value     = dir_rows[i].value;
            r.min_width = dir_rows[i].width;
            send_req(r, dir_rows[i].fixed, dir_rows[i].resp);
        end
        drain_chars();

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if ((i % 30) == 0)
                req_calm = ($urandom_range(0, 2) == 0);

            // Value: mostly k-digit magnitudes with a random sign, some full-range
            // words, and now and then one of the corner values.
            pick = $urandom_range(0, 9);
            if (pick == 0)
                r.value = $urandom;
            else if (pick == 1)
            begin
                case ($urandom_range(0, 3))
                    0: r.value = 32'sh8000_0000;
                    1: r.value = 32'sh7fff_ffff;
                    2: r.value = 32'sd0;
                    default: r.value = -32'sd1;
                endcase
            end
            else
            begin
                k   = $urandom_range(1, 10);
                p10 = 1;
                repeat ((k > 9) ? 9 : k) p10 = p10 * 10;
                mag = (k > 9) ? 32'($urandom) : 32'($urandom % p10);
                r.value = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
            end

            // Width: mostly legal (none, or between the bare length and the limit),
            // some deliberately too narrow, the rest anywhere in the 7-bit field.
            natural = natural_len(r.value);
            pick    = $urandom_range(0, 99);
            if (pick < 20)
                r.min_width = 7'd0;
            else if (pick < 80)
                r.min_width = 7'($urandom_range(natural, WIDTH_LIMIT));
            else if (pick < 88 && natural > 1)
                r.min_width = 7'($urandom_range(1, natural - 1));
            else
                r.min_width = 7'($urandom_range(0, 127));

            send_req(r, 1'b0, '0);
            if ((i % DRAIN_EVERY) == DRAIN_EVERY - 1)
                drain_chars();
        end

        drain_chars();
        repeat (TAIL_CYCLES) @(posedge clk);

        // Whatever is still queued never came out.
        while (expected_chars.size() != 0)
            note_mismatch("missing character", expected_chars.pop_front(), '0);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/itda_pkg.sv
hw/rtl/itda_bcd_cell.sv
hw/rtl/int_to_decimal_ascii_padded.sv
tb/sv/int_to_decimal_ascii_padded_test.sv
